>>> rtl/tlca_pkg.sv
package tlca_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_W      = 10;
    localparam int CNT_W       = 11;
    localparam int LIFT_LEVELS = 11;
    localparam int LVL_W       = 4;
    localparam int EDGE_CAP    = 2 * (MAX_NODES - 1);
    localparam int EDGE_W      = 11;
    localparam int ANC_AW      = NODE_W + LVL_W;
    localparam int ANC_DEPTH   = 1 << ANC_AW;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [EDGE_W-1:0] t_edge;
    typedef logic [LVL_W-1:0]  t_lvl;
    typedef logic [1:0]        t_func;
    typedef logic [2:0]        t_stat;

    localparam t_edge NO_EDGE   = t_edge'(EDGE_CAP);
    localparam t_cnt  UNVISITED = '1;

    localparam t_func FN_ADD   = 2'd0;
    localparam t_func FN_BUILD = 2'd1;
    localparam t_func FN_LCA   = 2'd2;
    localparam t_func FN_KTH   = 2'd3;

    localparam t_stat ST_OK    = 3'd0;
    localparam t_stat ST_FULL  = 3'd1;
    localparam t_stat ST_RANGE = 3'd2;
    localparam t_stat ST_NOTBLT = 3'd3;
    localparam t_stat ST_UNREACH = 3'd4;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_ROOT_NODE  = 1'b1;

    typedef struct packed {
        t_cnt  node_count;
        t_node root_node;
    } t_cfg;

    typedef struct packed {
        t_cnt  answer_node;
        t_cnt  path_length;
        t_stat status;
    } t_res;

    function automatic logic [ANC_AW-1:0] anc_addr(input t_node node, input t_lvl lvl);
        anc_addr = {node, lvl};
    endfunction

endpackage

>>> rtl/tlca_if.sv
interface tlca_in_if;
    import tlca_pkg::*;
    logic  valid;
    logic  ready;
    t_func func;
    t_node node_a;
    t_node node_b;
    t_node step_count;
    modport source (output valid, func, node_a, node_b, step_count, input ready);
    modport sink (input valid, func, node_a, node_b, step_count, output ready);
endinterface

interface tlca_out_if;
    import tlca_pkg::*;
    logic  valid;
    logic  ready;
    t_cnt  answer_node;
    t_cnt  path_length;
    t_stat status;
    modport source (output valid, answer_node, path_length, status, input ready);
    modport sink (input valid, answer_node, path_length, status, output ready);
endinterface

>>> rtl/tree_lca_binary_lifting_unit.sv
// Lowest common ancestor and k-th ancestor engine over up to 1024 tree nodes,
// using binary lifting. Items on the input channel: add edge (func 0), build
// (func 1), common ancestor with path length (func 2), k-th ancestor (func 3).
// Every item gives exactly one result word. One item is worked at a time; the
// tree state lives in synchronous memories with one write and one read port
// (edge lists, walk queue, node depths, 1024 x 16 ancestor table), and the
// item's latency is set by how many reads it must make through those read
// ports, one read per cycle, each read data registered. Add edge appends two
// directed entries. Common ancestor reads both depths, climbs the deeper node
// by the depth gap, one table read per set bit, and when neither node is an
// ancestor of the other lifts both top-down. K-th ancestor climbs the same
// way by step_count. Build resets the depth and parent rows, walks breadth-
// first from the root over the stored edge entries, then fills the doubling
// levels. After reset a clearing pass empties the adjacency heads of all
// 1024 nodes; the input channel is not ready until it ends (register
// writes still work). Registers: node_count at byte 0x0 (saturated into
// 1..1024, a write marks the table not built), root_node at 0x4. Write
// registers only while idle. A result word waits in an output register, so
// the next item is taken while it is still pending.
module tree_lca_binary_lifting_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tlca_in_if.sink                     in_ch,
    tlca_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlca_pkg::APB_AW-1:0] paddr,
    input  logic [tlca_pkg::APB_DW-1:0] pwdata,
    output logic [tlca_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import tlca_pkg::*;

    t_cfg cfg;
    logic count_wr;
    logic res_valid;
    logic res_ready;
    t_res res;
    logic r_out_valid;
    t_res r_out;

    tlca_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .o_count_wr (count_wr)
    );

    tlca_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_count_wr   (count_wr),
        .i_in_valid   (in_ch.valid),
        .o_in_ready   (in_ch.ready),
        .i_func       (in_ch.func),
        .i_node_a     (in_ch.node_a),
        .i_node_b     (in_ch.node_b),
        .i_step_count (in_ch.step_count),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output word register, refilled as soon as the pending word is taken
    assign res_ready = !r_out_valid || out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign out_ch.valid       = r_out_valid;
    assign out_ch.answer_node = r_out.answer_node;
    assign out_ch.path_length = r_out.path_length;
    assign out_ch.status      = r_out.status;
endmodule

>>> rtl/tlca_ram.sv
module tlca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/tlca_cfg.sv
module tlca_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tlca_pkg::APB_AW-1:0] paddr,
    input  logic [tlca_pkg::APB_DW-1:0] pwdata,
    output logic [tlca_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output tlca_pkg::t_cfg            o_cfg,
    output logic                      o_count_wr
);
    import tlca_pkg::*;

    t_cnt  r_count;
    t_node r_root;
    t_cnt  wr_count;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // saturate into 1..MAX_NODES
    always_comb begin
        wr_count = pwdata[CNT_W-1:0];
        if (wr_count == '0) begin
            wr_count = t_cnt'(1);
        end else if (wr_count > t_cnt'(MAX_NODES)) begin
            wr_count = t_cnt'(MAX_NODES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= t_cnt'(1);
            r_root  <= '0;
        end else if (wr_en) begin
            if (paddr[2] == REG_NODE_COUNT) begin
                r_count <= wr_count;
            end else begin
                r_root <= pwdata[NODE_W-1:0];
            end
        end
    end

    assign o_count_wr = wr_en && (paddr[2] == REG_NODE_COUNT);
    assign o_cfg      = '{node_count: r_count, root_node: r_root};
    assign prdata     = (paddr[2] == REG_ROOT_NODE) ? APB_DW'(r_root) : APB_DW'(r_count);
endmodule

>>> rtl/tlca_core.sv
module tlca_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlca_pkg::t_cfg    i_cfg,
    input  logic              i_count_wr,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tlca_pkg::t_func   i_func,
    input  tlca_pkg::t_node   i_node_a,
    input  tlca_pkg::t_node   i_node_b,
    input  tlca_pkg::t_node   i_step_count,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output tlca_pkg::t_res    o_res
);
    import tlca_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_ADD_RD  = 5'd2;
    localparam logic [4:0] S_ADD_W1  = 5'd3;
    localparam logic [4:0] S_ADD_W2  = 5'd4;
    localparam logic [4:0] S_B_INIT  = 5'd5;
    localparam logic [4:0] S_B_ROOT  = 5'd6;
    localparam logic [4:0] S_B_POP   = 5'd7;
    localparam logic [4:0] S_B_V     = 5'd8;
    localparam logic [4:0] S_B_E     = 5'd9;
    localparam logic [4:0] S_B_EDGE  = 5'd10;
    localparam logic [4:0] S_B_T     = 5'd11;
    localparam logic [4:0] S_B_D     = 5'd12;
    localparam logic [4:0] S_D_RD1   = 5'd13;
    localparam logic [4:0] S_D_RD2   = 5'd14;
    localparam logic [4:0] S_D_WR    = 5'd15;
    localparam logic [4:0] S_Q_A     = 5'd16;
    localparam logic [4:0] S_Q_B     = 5'd17;
    localparam logic [4:0] S_Q_C     = 5'd18;
    localparam logic [4:0] S_K_A     = 5'd19;
    localparam logic [4:0] S_K_B     = 5'd20;
    localparam logic [4:0] S_CL      = 5'd21;
    localparam logic [4:0] S_CL_W    = 5'd22;
    localparam logic [4:0] S_CL_END  = 5'd23;
    localparam logic [4:0] S_L_RU    = 5'd24;
    localparam logic [4:0] S_L_RV    = 5'd25;
    localparam logic [4:0] S_L_CMP   = 5'd26;
    localparam logic [4:0] S_L_P     = 5'd27;
    localparam logic [4:0] S_L_PW    = 5'd28;
    localparam logic [4:0] S_L_LEN0  = 5'd29;
    localparam logic [4:0] S_L_LEN   = 5'd30;
    localparam logic [4:0] S_DONE    = 5'd31;

    localparam logic RET_LCA = 1'b0;
    localparam logic RET_KTH = 1'b1;

    logic [4:0] r_state, n_state;
    t_cnt  r_i, n_i;
    t_lvl  r_j, n_j;
    t_cnt  r_head, n_head;
    t_cnt  r_tail, n_tail;
    t_edge r_used, n_used;
    logic  r_built, n_built;
    t_node r_a, n_a;
    t_node r_b, n_b;
    t_node r_k, n_k;
    t_cnt  r_u, n_u;
    t_cnt  r_v, n_v;
    t_cnt  r_da, n_da;
    t_cnt  r_db, n_db;
    t_cnt  r_dv, n_dv;
    t_edge r_e, n_e;
    t_node r_d, n_d;
    t_lvl  r_lvl, n_lvl;
    t_cnt  r_au, n_au;
    logic  r_side, n_side;
    logic  r_ret, n_ret;
    t_res  r_res, n_res;

    // memory ports
    logic        et_we;  t_edge et_wa;  t_node et_wd;  t_edge et_ra;  t_node et_rd;
    logic        ln_we;  t_edge ln_wa;  t_edge ln_wd;  t_edge ln_ra;  t_edge ln_rd;
    logic        ef_we;  t_node ef_wa;  t_edge ef_wd;  t_node ef_ra;  t_edge ef_rd;
    logic        el_we;  t_node el_wa;  t_edge el_wd;  t_node el_ra;  t_edge el_rd;
    logic        wq_we;  t_node wq_wa;  t_node wq_wd;  t_node wq_ra;  t_node wq_rd;
    logic        dp_we;  t_node dp_wa;  t_cnt  dp_wd;  t_node dp_ra;  t_cnt  dp_rd;
    logic        an_we;
    logic [ANC_AW-1:0] an_wa;
    t_cnt        an_wd;
    logic [ANC_AW-1:0] an_ra;
    t_cnt        an_rd;

    t_cnt  n_cnt;
    t_node add_from;
    t_node add_to;
    logic  dbl_next;
    logic [CNT_W:0] len_sum;

    tlca_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_CAP)) u_edge_target (
        .i_clk(i_clk), .i_we(et_we), .i_waddr(et_wa), .i_wdata(et_wd),
        .i_raddr(et_ra), .o_rdata(et_rd));
    tlca_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_CAP)) u_edge_link (
        .i_clk(i_clk), .i_we(ln_we), .i_waddr(ln_wa), .i_wdata(ln_wd),
        .i_raddr(ln_ra), .o_rdata(ln_rd));
    tlca_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_first_edge (
        .i_clk(i_clk), .i_we(ef_we), .i_waddr(ef_wa), .i_wdata(ef_wd),
        .i_raddr(ef_ra), .o_rdata(ef_rd));
    tlca_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES)) u_last_edge (
        .i_clk(i_clk), .i_we(el_we), .i_waddr(el_wa), .i_wdata(el_wd),
        .i_raddr(el_ra), .o_rdata(el_rd));
    tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_walk_queue (
        .i_clk(i_clk), .i_we(wq_we), .i_waddr(wq_wa), .i_wdata(wq_wd),
        .i_raddr(wq_ra), .o_rdata(wq_rd));
    tlca_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_node_depth (
        .i_clk(i_clk), .i_we(dp_we), .i_waddr(dp_wa), .i_wdata(dp_wd),
        .i_raddr(dp_ra), .o_rdata(dp_rd));
    tlca_ram #(.WIDTH(CNT_W), .DEPTH(ANC_DEPTH)) u_ancestor (
        .i_clk(i_clk), .i_we(an_we), .i_waddr(an_wa), .i_wdata(an_wd),
        .i_raddr(an_ra), .o_rdata(an_rd));

    assign n_cnt    = i_cfg.node_count;
    assign add_from = r_side ? r_b : r_a;
    assign add_to   = r_side ? r_a : r_b;
    assign len_sum  = {1'b0, r_da} + {1'b0, r_db} - {dp_rd, 1'b0};

    always_comb begin
        n_state = r_state;  n_i = r_i;  n_j = r_j;  n_head = r_head;  n_tail = r_tail;
        n_used = r_used;  n_built = r_built;  n_a = r_a;  n_b = r_b;  n_k = r_k;
        n_u = r_u;  n_v = r_v;  n_da = r_da;  n_db = r_db;  n_dv = r_dv;  n_e = r_e;
        n_d = r_d;  n_lvl = r_lvl;  n_au = r_au;  n_side = r_side;  n_ret = r_ret;
        n_res = r_res;
        dbl_next = 1'b0;
        et_we = 1'b0;  et_wa = r_used;  et_wd = add_to;  et_ra = r_e;
        ln_we = 1'b0;  ln_wa = r_used;  ln_wd = NO_EDGE;  ln_ra = r_e;
        ef_we = 1'b0;  ef_wa = add_from;  ef_wd = r_used;  ef_ra = add_from;
        el_we = 1'b0;  el_wa = add_from;  el_wd = r_used;  el_ra = add_from;
        wq_we = 1'b0;  wq_wa = r_tail[NODE_W-1:0];  wq_wd = r_d;  wq_ra = r_head[NODE_W-1:0];
        dp_we = 1'b0;  dp_wa = r_d;  dp_wd = r_dv + t_cnt'(1);  dp_ra = r_a;
        an_we = 1'b0;  an_wa = anc_addr(r_i[NODE_W-1:0], r_j);  an_wd = n_cnt;
        an_ra = anc_addr(r_v[NODE_W-1:0], r_lvl);

        case (r_state)
            S_CLR: begin
                ef_we = 1'b1;
                ef_wa = r_i[NODE_W-1:0];
                ef_wd = NO_EDGE;
                n_i   = r_i + t_cnt'(1);
                if (r_i[NODE_W-1:0] == t_node'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a = i_node_a;
                    n_b = i_node_b;
                    n_k = i_step_count;
                    n_res = '{answer_node: n_cnt, path_length: '0, status: ST_OK};
                    n_state = S_DONE;
                    case (i_func)
                        FN_ADD: begin
                            if ({1'b0, i_node_a} >= n_cnt || {1'b0, i_node_b} >= n_cnt) begin
                                n_res.status = ST_RANGE;
                            end else if ({1'b0, r_used} + 12'd2 > 12'(EDGE_CAP)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_side  = 1'b0;
                                n_state = S_ADD_RD;
                            end
                        end
                        FN_BUILD: begin
                            if ({1'b0, i_cfg.root_node} >= n_cnt) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                n_i     = '0;
                                n_state = S_B_INIT;
                            end
                        end
                        FN_LCA: begin
                            if ({1'b0, i_node_a} >= n_cnt || {1'b0, i_node_b} >= n_cnt) begin
                                n_res.status = ST_RANGE;
                            end else if (!r_built) begin
                                n_res.status = ST_NOTBLT;
                            end else begin
                                n_state = S_Q_A;
                            end
                        end
                        default: begin
                            if ({1'b0, i_node_b} >= n_cnt) begin
                                n_res.status = ST_RANGE;
                            end else if (!r_built) begin
                                n_res.status = ST_NOTBLT;
                            end else begin
                                n_state = S_K_A;
                            end
                        end
                    endcase
                end
            end
            // append one directed entry to the tail of a node's list
            S_ADD_RD: begin
                n_state = S_ADD_W1;
            end
            S_ADD_W1: begin
                et_we = 1'b1;
                el_we = 1'b1;
                if (ef_rd == NO_EDGE) begin
                    ef_we = 1'b1;
                end else begin
                    ln_we = 1'b1;
                    ln_wa = el_rd;
                    ln_wd = r_used;
                end
                n_state = S_ADD_W2;
            end
            S_ADD_W2: begin
                ln_we  = 1'b1;
                n_used = r_used + t_edge'(1);
                if (r_side) begin
                    n_state = S_DONE;
                end else begin
                    n_side  = 1'b1;
                    n_state = S_ADD_RD;
                end
            end
            // build: reset depth and parent rows, then walk breadth-first
            S_B_INIT: begin
                dp_we = 1'b1;
                dp_wa = r_i[NODE_W-1:0];
                dp_wd = UNVISITED;
                an_we = 1'b1;
                an_wa = anc_addr(r_i[NODE_W-1:0], '0);
                n_i   = r_i + t_cnt'(1);
                if (r_i + t_cnt'(1) == n_cnt) begin
                    n_state = S_B_ROOT;
                end
            end
            S_B_ROOT: begin
                dp_we  = 1'b1;
                dp_wa  = i_cfg.root_node;
                dp_wd  = '0;
                wq_we  = 1'b1;
                wq_wa  = '0;
                wq_wd  = i_cfg.root_node;
                n_head = '0;
                n_tail = t_cnt'(1);
                n_state = S_B_POP;
            end
            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_i     = '0;
                    n_j     = t_lvl'(1);
                    n_state = S_D_RD1;
                end else begin
                    n_head  = r_head + t_cnt'(1);
                    n_state = S_B_V;
                end
            end
            S_B_V: begin
                n_v   = {1'b0, wq_rd};
                ef_ra = wq_rd;
                dp_ra = wq_rd;
                n_state = S_B_E;
            end
            S_B_E: begin
                n_e  = ef_rd;
                n_dv = dp_rd;
                n_state = S_B_EDGE;
            end
            S_B_EDGE: begin
                if (r_e == NO_EDGE) begin
                    n_state = S_B_POP;
                end else begin
                    n_state = S_B_T;
                end
            end
            S_B_T: begin
                n_d = et_rd;
                n_e = ln_rd;
                if ({1'b0, et_rd} >= n_cnt) begin
                    n_state = S_B_EDGE;
                end else begin
                    dp_ra   = et_rd;
                    n_state = S_B_D;
                end
            end
            S_B_D: begin
                if (dp_rd == UNVISITED) begin
                    an_we  = 1'b1;
                    an_wa  = anc_addr(r_d, '0);
                    an_wd  = r_v;
                    dp_we  = 1'b1;
                    wq_we  = 1'b1;
                    n_tail = r_tail + t_cnt'(1);
                end
                n_state = S_B_EDGE;
            end
            // doubling: anc(i,j) = anc(anc(i,j-1),j-1)
            S_D_RD1: begin
                an_ra   = anc_addr(r_i[NODE_W-1:0], r_j - t_lvl'(1));
                n_state = S_D_RD2;
            end
            S_D_RD2: begin
                if (an_rd >= n_cnt) begin
                    an_we    = 1'b1;
                    dbl_next = 1'b1;
                end else begin
                    an_ra   = anc_addr(an_rd[NODE_W-1:0], r_j - t_lvl'(1));
                    n_state = S_D_WR;
                end
            end
            S_D_WR: begin
                an_we    = 1'b1;
                an_wd    = an_rd;
                dbl_next = 1'b1;
            end
            // common ancestor: depths, then level the deeper node
            S_Q_A: begin
                dp_ra   = r_a;
                n_state = S_Q_B;
            end
            S_Q_B: begin
                n_da    = dp_rd;
                dp_ra   = r_b;
                n_state = S_Q_C;
            end
            S_Q_C: begin
                n_db = dp_rd;
                if (r_da == UNVISITED || dp_rd == UNVISITED) begin
                    n_res.status = ST_UNREACH;
                    n_state = S_DONE;
                end else begin
                    if (r_da > dp_rd) begin
                        n_u = {1'b0, r_b};
                        n_v = {1'b0, r_a};
                        n_k = t_node'(r_da - dp_rd);
                    end else begin
                        n_u = {1'b0, r_a};
                        n_v = {1'b0, r_b};
                        n_k = t_node'(dp_rd - r_da);
                    end
                    n_lvl   = '0;
                    n_ret   = RET_LCA;
                    n_state = S_CL;
                end
            end
            S_K_A: begin
                dp_ra   = r_b;
                n_state = S_K_B;
            end
            S_K_B: begin
                if (dp_rd == UNVISITED) begin
                    n_res.status = ST_UNREACH;
                    n_state = S_DONE;
                end else begin
                    n_v     = {1'b0, r_b};
                    n_lvl   = '0;
                    n_ret   = RET_KTH;
                    n_state = S_CL;
                end
            end
            // climb r_k levels, one set bit per table read
            S_CL: begin
                if (r_k == '0 || r_v >= n_cnt) begin
                    n_state = S_CL_END;
                end else if (r_k[0]) begin
                    if (r_lvl >= t_lvl'(LIFT_LEVELS)) begin
                        n_v     = n_cnt;
                        n_state = S_CL_END;
                    end else begin
                        n_state = S_CL_W;
                    end
                end else begin
                    n_k   = r_k >> 1;
                    n_lvl = r_lvl + t_lvl'(1);
                end
            end
            S_CL_W: begin
                n_v     = an_rd;
                n_k     = r_k >> 1;
                n_lvl   = r_lvl + t_lvl'(1);
                n_state = S_CL;
            end
            S_CL_END: begin
                if (r_ret == RET_KTH) begin
                    n_res.answer_node = (r_v >= n_cnt) ? n_cnt : r_v;
                    n_state = S_DONE;
                end else if (r_u == r_v) begin
                    n_state = S_L_LEN0;
                end else if (r_v >= n_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl   = t_lvl'(LIFT_LEVELS - 1);
                    n_state = S_L_RU;
                end
            end
            // top-down lift of both nodes while their ancestors differ
            S_L_RU: begin
                an_ra   = anc_addr(r_u[NODE_W-1:0], r_lvl);
                n_state = S_L_RV;
            end
            S_L_RV: begin
                n_au    = an_rd;
                n_state = S_L_CMP;
            end
            S_L_CMP: begin
                if (r_au != an_rd) begin
                    n_u = r_au;
                    n_v = an_rd;
                end
                if (r_lvl == '0) begin
                    n_state = S_L_P;
                end else begin
                    n_lvl   = r_lvl - t_lvl'(1);
                    n_state = S_L_RU;
                end
            end
            S_L_P: begin
                an_ra   = anc_addr(r_u[NODE_W-1:0], '0);
                n_state = S_L_PW;
            end
            S_L_PW: begin
                n_u     = an_rd;
                n_state = S_L_LEN0;
            end
            S_L_LEN0: begin
                n_res.answer_node = r_u;
                dp_ra   = r_u[NODE_W-1:0];
                n_state = S_L_LEN;
            end
            S_L_LEN: begin
                n_res.path_length = len_sum[CNT_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (dbl_next) begin
            n_state = S_D_RD1;
            if (r_i + t_cnt'(1) == n_cnt) begin
                n_i = '0;
                if (r_j == t_lvl'(LIFT_LEVELS - 1)) begin
                    n_built = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_j = r_j + t_lvl'(1);
                end
            end else begin
                n_i = r_i + t_cnt'(1);
            end
        end

        if (i_count_wr) begin
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i     <= '0;
            r_used  <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_used  <= n_used;
            r_built <= n_built;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j;  r_head <= n_head;  r_tail <= n_tail;  r_a <= n_a;  r_b <= n_b;
        r_k <= n_k;  r_u <= n_u;  r_v <= n_v;  r_da <= n_da;  r_db <= n_db;
        r_dv <= n_dv;  r_e <= n_e;  r_d <= n_d;  r_lvl <= n_lvl;  r_au <= n_au;
        r_side <= n_side;  r_ret <= n_ret;  r_res <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
endmodule

>>> rtl/tlca_checker.sv
module tlca_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input tlca_pkg::t_cnt  i_path_length,
    input tlca_pkg::t_stat i_status
);
    import tlca_pkg::*;

    // one item at a time: no second word taken right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("stalled result word dropped or changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_FULL ||
                         i_status == ST_RANGE || i_status == ST_NOTBLT ||
                         i_status == ST_UNREACH))
        else $error("status code out of range");

    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_path_length == '0))
        else $error("path length nonzero on error");
endmodule

bind tree_lca_binary_lifting_unit tlca_checker u_tlca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_path_length (out_ch.path_length),
    .i_status      (out_ch.status)
);

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import tlca_pkg::*;

    localparam int STALL_LIMIT = 300000;
    localparam int ITEM_GOAL   = 1850;

    typedef struct {
        bit    cfg;
        int    cfg_n;
        int    cfg_root;
        t_func func;
        int    a;
        int    b;
        int    k;
        bit    typed;
        int    ans;
        int    len;
        t_stat st;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    tlca_in_if  in_ch ();
    tlca_out_if out_ch ();

    tree_lca_binary_lifting_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the tree engine state
    t_node  edge_dst  [EDGE_CAP];
    t_edge  edge_nxt  [EDGE_CAP];
    t_edge  list_head [MAX_NODES];
    int     edge_cnt;
    t_cnt   lvl_of    [MAX_NODES];
    t_cnt   lift      [MAX_NODES+1][LIFT_LEVELS];
    bit     lift_ready;
    int     cur_n;
    int     cur_root;

    t_res   answer_q[$];
    int     words_sent;
    int     fail_cnt;
    int     idle_mode;       // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    bit     moved;           // any handshake this cycle, for the watchdog
    int     quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void shadow_reset();
        for (int i = 0; i < MAX_NODES; i++) begin
            list_head[i] = NO_EDGE;
            lvl_of[i]    = UNVISITED;
        end
        edge_cnt   = 0;
        lift_ready = 0;
        cur_n      = 1;
        cur_root   = 0;
    endfunction

    function automatic void shadow_link(int from, int to);
        int p;
        edge_dst[edge_cnt] = t_node'(to);
        edge_nxt[edge_cnt] = NO_EDGE;
        if (list_head[from] == NO_EDGE) begin
            list_head[from] = t_edge'(edge_cnt);
        end else begin
            p = list_head[from];
            while (edge_nxt[p] != NO_EDGE) p = edge_nxt[p];
            edge_nxt[p] = t_edge'(edge_cnt);
        end
        edge_cnt++;
    endfunction

    // breadth-first walk from the root, then doubling
    function automatic void shadow_build();
        int fifo [MAX_NODES];
        int rd, wr, v, d, e;
        rd = 0;
        wr = 0;
        for (int i = 0; i <= cur_n; i++)
            for (int j = 0; j < LIFT_LEVELS; j++) lift[i][j] = t_cnt'(cur_n);
        for (int i = 0; i < cur_n; i++) lvl_of[i] = UNVISITED;
        lvl_of[cur_root] = '0;
        fifo[wr++] = cur_root;
        while (rd < wr) begin
            v = fifo[rd++];
            for (e = list_head[v]; e != NO_EDGE; e = edge_nxt[e]) begin
                d = edge_dst[e];
                if (d >= cur_n || lvl_of[d] != UNVISITED) continue;
                lift[d][0] = t_cnt'(v);
                lvl_of[d]  = t_cnt'(lvl_of[v] + 1);
                fifo[wr++] = d;
            end
        end
        for (int j = 1; j < LIFT_LEVELS && (1 << j) < cur_n; j++)
            for (int i = 0; i < cur_n; i++) lift[i][j] = lift[lift[i][j-1]][j-1];
        lift_ready = 1;
    endfunction

    function automatic int climb_up(int v, int k);
        for (int i = 0; k != 0; i++, k >>= 1) begin
            if (k & 1) begin
                if (i >= LIFT_LEVELS) return cur_n;
                v = lift[v][i];
            end
        end
        return v;
    endfunction

    function automatic int meet_point(int u, int v);
        int t;
        if (lvl_of[u] > lvl_of[v]) begin
            t = u; u = v; v = t;
        end
        v = climb_up(v, lvl_of[v] - lvl_of[u]);
        if (u == v) return u;
        if (v >= cur_n) return cur_n;
        for (int i = LIFT_LEVELS - 1; i >= 0; i--) begin
            if (lift[u][i] != lift[v][i]) begin
                u = lift[u][i];
                v = lift[v][i];
            end
        end
        return lift[u][0];
    endfunction

    function automatic t_res tree_answer(t_func f, int a, int b, int k);
        t_res r;
        int c;
        r.answer_node = t_cnt'(cur_n);
        r.path_length = '0;
        r.status      = ST_OK;
        case (f)
            FN_ADD: begin
                if (a >= cur_n || b >= cur_n) r.status = ST_RANGE;
                else if (edge_cnt + 2 > EDGE_CAP) r.status = ST_FULL;
                else begin
                    shadow_link(a, b);
                    shadow_link(b, a);
                end
            end
            FN_BUILD: begin
                if (cur_root >= cur_n) r.status = ST_RANGE;
                else shadow_build();
            end
            FN_LCA: begin
                if (a >= cur_n || b >= cur_n) r.status = ST_RANGE;
                else if (!lift_ready) r.status = ST_NOTBLT;
                else if (lvl_of[a] == UNVISITED || lvl_of[b] == UNVISITED)
                    r.status = ST_UNREACH;
                else begin
                    c = meet_point(a, b);
                    r.answer_node = t_cnt'(c);
                    if (c < cur_n)
                        r.path_length = t_cnt'(lvl_of[a] + lvl_of[b] - 2 * lvl_of[c]);
                end
            end
            default: begin
                if (b >= cur_n) r.status = ST_RANGE;
                else if (!lift_ready) r.status = ST_NOTBLT;
                else if (lvl_of[b] == UNVISITED) r.status = ST_UNREACH;
                else r.answer_node = t_cnt'(climb_up(b, k));
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result side: random stall, compare against oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (answer_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result word ans=%0d len=%0d st=%0d",
                             out_ch.answer_node, out_ch.path_length, out_ch.status);
            end else begin
                want = answer_q.pop_front();
                if (want.answer_node !== out_ch.answer_node ||
                    want.path_length !== out_ch.path_length ||
                    want.status !== out_ch.status) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("result mismatch: exp ans=%0d len=%0d st=%0d, got ans=%0d len=%0d st=%0d",
                                 want.answer_node, want.path_length, want.status,
                                 out_ch.answer_node, out_ch.path_length, out_ch.status);
                end
            end
        end
        if (idle_mode == 2) out_ch.ready <= ($urandom_range(0, 99) >= 72);
        else if (idle_mode == 3) out_ch.ready <= ($urandom_range(0, 99) >= 14);
        else out_ch.ready <= 1'b1;
    end

    // watchdog: cycles in a row with no handshake on either channel
    always @(posedge i_clk) begin
        moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
        if (moved) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    // one input word; valid stays up into the next word unless we idle
    task automatic send_word(t_func f, int a, int b, int k, bit typed, t_res typed_res);
        t_res r;
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 14 : 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < gap_pct) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= f;
        in_ch.node_a     <= t_node'(a);
        in_ch.node_b     <= t_node'(b);
        in_ch.step_count <= t_node'(k);
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = tree_answer(f, a, b, k);
        answer_q.push_back(typed ? typed_res : r);
        words_sent++;
    endtask

    task automatic send_op(t_func f, int a, int b, int k);
        send_word(f, a, b, k, 1'b0, '0);
    endtask

    task automatic apb_write(logic idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers move only with the engine idle: nothing owed, then a short pause
    task automatic set_tree(int n_raw, int root);
        int n;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        apb_write(REG_NODE_COUNT, n_raw);
        apb_write(REG_ROOT_NODE, root);
        n = n_raw & 'h7ff;
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        cur_n      = n;
        cur_root   = root & 'h3ff;
        lift_ready = 0;
    endtask

    function automatic t_dir_row mk(bit cfg, int cn, int cr, t_func f, int a, int b, int k,
                                    int ans, int len, t_stat st);
        t_dir_row r;
        r.cfg = cfg; r.cfg_n = cn; r.cfg_root = cr;
        r.func = f; r.a = a; r.b = b; r.k = k;
        r.typed = 1'b1; r.ans = ans; r.len = len; r.st = st;
        return r;
    endfunction

    // random node: mostly inside the tree, now and then any 10-bit value
    function automatic int pick_node(int n);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, n - 1);
    endfunction

    task automatic random_phase(int ph);
        int n_raw, n, root, links, queries;
        int order[$];
        idle_mode = ph % 4;
        if (ph == 7 || ph == 22) n_raw = MAX_NODES;
        else if ($urandom_range(0, 11) == 0) n_raw = ($urandom_range(0, 1)) ? 0 : 2047;
        else if ($urandom_range(0, 11) == 0) n_raw = 1;
        else n_raw = $urandom_range(2, 40);
        // saturated huge counts are clipped to MAX_NODES, as the unit does
        n = (n_raw < 1) ? 1 : (n_raw > MAX_NODES) ? MAX_NODES : n_raw;
        if (n_raw == 2047) n = MAX_NODES;
        root = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
        set_tree(n_raw, root);

        if ($urandom_range(0, 2) == 0) send_op(FN_LCA, pick_node(n), pick_node(n), 0);

        // random tree rooted anywhere, fed as shuffled edges (only 200 of them when n > 48)
        for (int i = 0; i < n; i++) order.push_back(i);
        order.shuffle();
        links = (n > 48) ? 200 : n - 1;
        for (int i = 1; i <= links; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                if ($urandom_range(0, 1)) send_op(FN_ADD, $urandom_range(0, 1023),
                                                  $urandom_range(0, 1023), 0);
                else send_op(FN_ADD, order[i], order[i], 0);
            end
            send_op(FN_ADD, order[i], order[$urandom_range(0, i - 1)], $urandom_range(0, 1023));
        end
        if ($urandom_range(0, 9) != 0) send_op(FN_BUILD, $urandom_range(0, 1023),
                                              $urandom_range(0, 1023), $urandom_range(0, 1023));

        queries = $urandom_range(10, 30);
        for (int q = 0; q < queries; q++) begin
            case ($urandom_range(0, 19))
                0: send_op(FN_ADD, pick_node(n), pick_node(n), 0);
                1: if (n <= 48) send_op(FN_BUILD, 0, 0, 0);
                default: begin
                    if ($urandom_range(0, 1))
                        send_op(FN_LCA, pick_node(n), pick_node(n), $urandom_range(0, 1023));
                    else
                        send_op(FN_KTH, $urandom_range(0, 1023), pick_node(n),
                                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                            : $urandom_range(0, 12));
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        t_dir_row rows[$];
        int ph;
        t_res tr;

        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.func       = FN_ADD;
        in_ch.node_a     = '0;
        in_ch.node_b     = '0;
        in_ch.step_count = '0;
        out_ch.ready     = 1'b1;
        words_sent       = 0;
        fail_cnt         = 0;
        idle_mode        = 0;
        quiet_cycles     = 0;
        shadow_reset();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: one-node tree straight from reset, then a small fixed
        // tree, bad root, and the full 1024-node size with a far corner root
        rows.push_back(mk(0, 0, 0, FN_LCA,   0, 0, 0,       1, 0, ST_NOTBLT));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 0, 0,       1, 0, ST_NOTBLT));
        rows.push_back(mk(0, 0, 0, FN_ADD,   1023, 0, 0,    1, 0, ST_RANGE));
        rows.push_back(mk(0, 0, 0, FN_BUILD, 0, 0, 0,       1, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_LCA,   0, 0, 0,       0, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 0, 1023,    1, 0, ST_OK));
        rows.push_back(mk(1, 8, 0, FN_ADD,   0, 1, 0,       8, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_ADD,   1, 2, 0,       8, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_ADD,   2, 3, 0,       8, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_ADD,   0, 4, 0,       8, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_ADD,   5, 5, 0,       8, 0, ST_OK));   // self loop
        rows.push_back(mk(0, 0, 0, FN_BUILD, 0, 0, 0,       8, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_LCA,   3, 4, 0,       0, 4, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 3, 3,       0, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 3, 4,       8, 0, ST_OK));   // past root
        rows.push_back(mk(0, 0, 0, FN_LCA,   6, 0, 0,       8, 0, ST_UNREACH));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 7, 0,       8, 0, ST_UNREACH));
        rows.push_back(mk(0, 0, 0, FN_LCA,   1023, 0, 0,    8, 0, ST_RANGE));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 1023, 0,    8, 0, ST_RANGE));
        rows.push_back(mk(1, 8, 1023, FN_BUILD, 0, 0, 0,    8, 0, ST_RANGE));
        rows.push_back(mk(0, 0, 0, FN_LCA,   0, 1, 0,       8, 0, ST_NOTBLT));
        rows.push_back(mk(1, 2047, 1023, FN_BUILD, 0, 0, 0, 1024, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_LCA,   1023, 1023, 0, 1023, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_KTH,   0, 1023, 1,    1024, 0, ST_OK));
        rows.push_back(mk(0, 0, 0, FN_LCA,   0, 1023, 0,    1024, 0, ST_UNREACH));

        foreach (rows[i]) begin
            if (rows[i].cfg) set_tree(rows[i].cfg_n, rows[i].cfg_root);
            tr.answer_node = t_cnt'(rows[i].ans);
            tr.path_length = t_cnt'(rows[i].len);
            tr.status      = rows[i].st;
            send_word(rows[i].func, rows[i].a, rows[i].b, rows[i].k, rows[i].typed, tr);
        end

        // random phases rotate through the idling patterns
        ph = 0;
        while (words_sent < ITEM_GOAL) begin
            random_phase(ph);
            ph++;
        end

        in_ch.valid <= 1'b0;
        idle_mode = 0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (fail_cnt == 0 && answer_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> tree_lca_binary_lifting_unit.f
rtl/tlca_pkg.sv
rtl/tlca_if.sv
rtl/tlca_ram.sv
rtl/tlca_cfg.sv
rtl/tlca_core.sv
rtl/tree_lca_binary_lifting_unit.sv
rtl/tlca_checker.sv
tb/tb.sv
